### hw/rtl/fsts_pkg.sv
// Shared types and constants for the floppy sector transfer sequencer.
// Used by the front, divider, back and top modules; no dependencies.
`timescale 1ns / 1ps
package fsts_pkg;

  localparam logic [1:0] MaxTries = 2'd3;

  localparam logic [1:0] OK_CMD  = 2'd0;
  localparam logic [1:0] OK_DOR  = 2'd1;
  localparam logic [1:0] OK_DMA  = 2'd2;
  localparam logic [1:0] OK_DONE = 2'd3;

  localparam logic [2:0] K_SET    = 3'd0;
  localparam logic [2:0] K_REQ    = 3'd1;
  localparam logic [2:0] K_STAT   = 3'd2;
  localparam logic [2:0] K_IRQ    = 3'd3;
  localparam logic [2:0] K_TICK   = 3'd4;
  localparam logic [2:0] K_MON    = 3'd5;
  localparam logic [2:0] K_MOFF   = 3'd6;

  localparam logic [2:0] R_SEEK  = 3'd0;
  localparam logic [2:0] R_SENSE = 3'd1;
  localparam logic [2:0] R_READ  = 3'd2;
  localparam logic [2:0] R_WRITE = 3'd3;
  localparam logic [2:0] R_RECAL = 3'd4;
  localparam logic [2:0] R_DELAY = 3'd5;
  localparam logic [2:0] R_SPT   = 3'd6;
  localparam logic [2:0] R_HEADS = 3'd7;

  localparam logic [7:0] DorMotorOn  = 8'h1c;
  localparam logic [7:0] DorMotorOff = 8'h0c;

  localparam int QDepth = 2;

  // one queued event between the front and the back
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] block_number;
    logic        write_flag;
    logic [7:0]  status_byte;
    logic [15:0] elapsed_us;
  } evt_t;

  // one emitted result
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_v;
    logic       dma_write;
    logic [1:0] done_status;
    logic       last;
  } res_t;

endpackage

### hw/rtl/fsts_front.sv
// Front end: accepts input beats into a short queue for the back end.
// Depends on fsts_pkg.
`timescale 1ns / 1ps
module fsts_front
  import fsts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  evt_t       in_evt_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output evt_t       q_evt_o
);
  evt_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'(QDepth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_evt_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_evt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count lost a push");
endmodule

### hw/rtl/fsts_div.sv
// Restoring divider for the block number mapping, one quotient bit per cycle.
// Depends on fsts_pkg.
`timescale 1ns / 1ps
module fsts_div
  import fsts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        busy_o,
  output logic [15:0] quot_o,
  output logic [6:0]  rem_o
);
  logic [15:0] quot_q;
  logic [6:0]  rem_q;
  logic [6:0]  dvs_q;
  logic [4:0]  cnt_q;
  logic [7:0]  trial;

  assign busy_o = (cnt_q != 5'd0);
  assign quot_o = quot_q;
  assign rem_o = rem_q;
  assign trial = {rem_q, quot_q[15]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (start_i) begin
      cnt_q <= 5'd16;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q <= 7'd0;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      if (!trial[7]) begin
        rem_q <= trial[6:0];
        quot_q <= {quot_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[5:0], quot_q[15]};
        quot_q <= {quot_q[14:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> cnt_q == 5'd16)
    else $error("divider did not load");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |-> dvs_q != 7'd0)
    else $error("divide by zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |=> cnt_q == $past(cnt_q) - 5'd1)
    else $error("divider count skipped");
endmodule

### hw/rtl/fsts_back.sv
// Back end: transfer sequencer state, motor timer and result emitter.
// Depends on fsts_pkg and fsts_div.
`timescale 1ns / 1ps
module fsts_back
  import fsts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  evt_t        q_evt_i,
  input  logic [7:0]  seek_op_i,
  input  logic [7:0]  sense_op_i,
  input  logic [7:0]  read_op_i,
  input  logic [7:0]  write_op_i,
  input  logic [7:0]  recal_op_i,
  input  logic [23:0] delay_i,
  input  logic [5:0]  spt_i,
  input  logic [1:0]  heads_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        out_res_o
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_SEEK_IRQ, PH_SEEK_SENSE, PH_XFER_IRQ, PH_XFER_STAT,
    PH_RECAL_IRQ, PH_RECAL_SENSE
  } phase_e;
  typedef enum logic [1:0] {MOT_OFF, MOT_DLY, MOT_ON} motor_e;
  typedef enum logic [2:0] {
    S_TAKE, S_DIV1, S_DIV2, S_EMIT
  } seq_e;
  // result script selectors
  typedef enum logic [2:0] {
    SC_NONE, SC_BUSY, SC_START, SC_SENSE, SC_RECAL, SC_DONE, SC_DOR
  } script_e;

  seq_e        seq_q;
  phase_e      phase_q;
  motor_e      motor_q;
  logic [24:0] cnt_q;
  logic [7:0]  track_q, headpos_q, st0_q, st1_q;
  logic        head_q, wr_q;
  logic [6:0]  sector_q;
  logic [1:0]  tries_q, done_st_q;
  logic [2:0]  await_q;
  logic        seek_q, dor_pre_q;
  logic [7:0]  dor_val_q;
  script_e     scr_q;
  logic [3:0]  idx_q, len_q;
  logic        out_valid_q;
  res_t        out_q;

  logic        div_start, div_busy;
  logic [15:0] div_dvd, div_quot;
  logic [6:0]  div_dvs, div_rem;
  logic [6:0]  spt_eff;
  logic [1:0]  h_eff;

  assign spt_eff = (spt_i == 6'd0) ? 7'd1 : {1'b0, spt_i};
  assign h_eff = (heads_i == 2'd0) ? 2'd1 : ((heads_i == 2'd3) ? 2'd2 : heads_i);

  fsts_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dvs), .busy_o(div_busy), .quot_o(div_quot), .rem_o(div_rem)
  );

  assign div_start = (seq_q == S_TAKE && q_valid_i && q_evt_i.kind == K_SET
                      && phase_q == PH_IDLE);
  assign div_dvd = q_evt_i.block_number;
  assign div_dvs = spt_eff;
  assign q_pop_o = (seq_q == S_TAKE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o = out_q;

  logic slot_free;
  assign slot_free = !out_valid_q || !out_stall_i;

  // produce element idx of the current script
  res_t cur;
  logic [3:0] k;
  always_comb begin
    cur = '0;
    k = idx_q;
    if (dor_pre_q) begin
      if (k == 4'd0) begin
        cur.kind = OK_DOR;
        cur.byte_v = DorMotorOn;
      end
      k = k - 4'd1;
    end
    case (scr_q)
      SC_BUSY, SC_DONE: begin
        cur.kind = OK_DONE;
        cur.done_status = done_st_q;
      end
      SC_SENSE: cur.byte_v = sense_op_i;
      SC_RECAL: cur.byte_v = (k == 4'd0) ? recal_op_i : 8'h00;
      SC_DOR: begin
        cur.kind = OK_DOR;
        cur.byte_v = dor_val_q;
      end
      SC_START: begin
        if (seek_q) begin
          case (k)
            4'd0: cur.byte_v = seek_op_i;
            4'd1: cur.byte_v = {5'd0, head_q, 2'd0};
            default: cur.byte_v = track_q;
          endcase
        end else begin
          case (k)
            4'd0: begin
              cur.kind = OK_DMA;
              cur.dma_write = wr_q;
            end
            4'd1: cur.byte_v = wr_q ? write_op_i : read_op_i;
            4'd2: cur.byte_v = {5'd0, head_q, 2'd0};
            4'd3: cur.byte_v = track_q;
            4'd4: cur.byte_v = {7'd0, head_q};
            4'd5: cur.byte_v = {1'b0, sector_q};
            4'd6: cur.byte_v = 8'h02;
            4'd7: cur.byte_v = 8'h12;
            4'd8: cur.byte_v = 8'h1b;
            default: cur.byte_v = 8'hff;
          endcase
        end
      end
      default: cur = cur;
    endcase
    if (dor_pre_q && idx_q == 4'd0) begin
      cur.kind = OK_DOR;
      cur.byte_v = DorMotorOn;
      cur.dma_write = 1'b0;
      cur.done_status = 2'd0;
    end
    cur.last = (idx_q == len_q - 4'd1);
  end

  // helpers used when a status phase ends
  logic st_fail_recal, st_ok;
  assign st_fail_recal = (st0_q[7:6] == 2'b01) && st1_q[2];
  assign st_ok = (st0_q[7:6] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [1:0] t;
    logic       nseek;
    if (!rst_ni) begin
      seq_q <= S_TAKE;
      phase_q <= PH_IDLE;
      motor_q <= MOT_OFF;
      cnt_q <= '0;
      track_q <= '0;
      head_q <= 1'b0;
      sector_q <= 7'd1;
      headpos_q <= 8'hff;
      wr_q <= 1'b0;
      tries_q <= '0;
      await_q <= '0;
      st0_q <= '0;
      st1_q <= '0;
      seek_q <= 1'b0;
      dor_pre_q <= 1'b0;
      dor_val_q <= '0;
      done_st_q <= '0;
      scr_q <= SC_NONE;
      idx_q <= '0;
      len_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      // the emit state owns the output register while it runs
      if (seq_q != S_EMIT && out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (seq_q)
        S_TAKE: begin
          idx_q <= '0;
          if (q_valid_i) begin
            case (q_evt_i.kind)
              K_SET: begin
                if (phase_q == PH_IDLE) begin
                  seq_q <= S_DIV1;
                end
              end
              K_REQ: begin
                if (phase_q != PH_IDLE) begin
                  scr_q <= SC_BUSY;
                  done_st_q <= 2'd2;
                  len_q <= 4'd1;
                  seq_q <= S_EMIT;
                end else begin
                  dor_pre_q <= (motor_q == MOT_OFF);
                  motor_q <= MOT_ON;
                  wr_q <= q_evt_i.write_flag;
                  tries_q <= MaxTries;
                  nseek = (track_q != headpos_q);
                  seek_q <= nseek;
                  headpos_q <= track_q;
                  phase_q <= nseek ? PH_SEEK_IRQ : PH_XFER_IRQ;
                  scr_q <= SC_START;
                  len_q <= (nseek ? 4'd3 : 4'd10) + ((motor_q == MOT_OFF) ? 4'd1 : 4'd0);
                  seq_q <= S_EMIT;
                end
              end
              K_IRQ: begin
                if (phase_q == PH_SEEK_IRQ || phase_q == PH_RECAL_IRQ) begin
                  phase_q <= (phase_q == PH_SEEK_IRQ) ? PH_SEEK_SENSE : PH_RECAL_SENSE;
                  await_q <= 3'd2;
                  scr_q <= SC_SENSE;
                  len_q <= 4'd1;
                  seq_q <= S_EMIT;
                end else if (phase_q == PH_XFER_IRQ) begin
                  phase_q <= PH_XFER_STAT;
                  await_q <= 3'd7;
                end
              end
              K_STAT: begin
                if (phase_q == PH_SEEK_SENSE || phase_q == PH_RECAL_SENSE ||
                    phase_q == PH_XFER_STAT) begin
                  if (phase_q == PH_XFER_STAT && await_q == 3'd7)
                    st0_q <= q_evt_i.status_byte;
                  if (phase_q == PH_XFER_STAT && await_q == 3'd6)
                    st1_q <= q_evt_i.status_byte;
                  if (await_q > 3'd1) begin
                    await_q <= await_q - 3'd1;
                  end else begin
                    await_q <= 3'd0;
                    seq_q <= S_DIV2; // resolve end of phase next cycle
                  end
                end
              end
              K_TICK: begin
                if (motor_q == MOT_DLY) begin
                  if ({9'd0, q_evt_i.elapsed_us} >= cnt_q) begin
                    cnt_q <= '0;
                    motor_q <= MOT_OFF;
                    scr_q <= SC_DOR;
                    dor_val_q <= DorMotorOff;
                    len_q <= 4'd1;
                    seq_q <= S_EMIT;
                  end else begin
                    cnt_q <= cnt_q - {9'd0, q_evt_i.elapsed_us};
                  end
                end
              end
              K_MON: begin
                if (motor_q == MOT_OFF) begin
                  scr_q <= SC_DOR;
                  dor_val_q <= DorMotorOn;
                  len_q <= 4'd1;
                  seq_q <= S_EMIT;
                end
                motor_q <= MOT_ON;
              end
              K_MOFF: begin
                if (motor_q == MOT_ON) begin
                  motor_q <= MOT_DLY;
                  cnt_q <= {1'b0, delay_i};
                end
              end
              default: seq_q <= S_TAKE;
            endcase
          end
        end
        S_DIV1: begin
          // wait for blk / spt, then map it to sector, head and track
          if (!div_busy && !div_start) begin
            sector_q <= div_rem + 7'd1;
            if (h_eff == 2'd2) begin
              head_q <= div_quot[0];
              track_q <= div_quot[8:1];
            end else begin
              head_q <= 1'b0;
              track_q <= div_quot[7:0];
            end
            seq_q <= S_TAKE;
          end
        end
        S_DIV2: begin
          // end of a status phase
          t = (tries_q > 2'd0) ? tries_q - 2'd1 : 2'd0;
          seq_q <= S_EMIT;
          if (phase_q == PH_SEEK_SENSE) begin
            seek_q <= 1'b0;
            phase_q <= PH_XFER_IRQ;
            scr_q <= SC_START;
            len_q <= 4'd10;
          end else if (phase_q == PH_XFER_STAT && st_fail_recal) begin
            headpos_q <= 8'd0;
            phase_q <= PH_RECAL_IRQ;
            scr_q <= SC_RECAL;
            len_q <= 4'd2;
          end else if (phase_q == PH_XFER_STAT && st_ok) begin
            phase_q <= PH_IDLE;
            scr_q <= SC_DONE;
            done_st_q <= 2'd0;
            len_q <= 4'd1;
            if (motor_q == MOT_ON) begin
              motor_q <= MOT_DLY;
              cnt_q <= {1'b0, delay_i};
            end
          end else begin
            tries_q <= t;
            if (t == 2'd0) begin
              phase_q <= PH_IDLE;
              scr_q <= SC_DONE;
              done_st_q <= 2'd1;
              len_q <= 4'd1;
              if (motor_q == MOT_ON) begin
                motor_q <= MOT_DLY;
                cnt_q <= {1'b0, delay_i};
              end
            end else begin
              nseek = (track_q != headpos_q);
              seek_q <= nseek;
              headpos_q <= track_q;
              phase_q <= nseek ? PH_SEEK_IRQ : PH_XFER_IRQ;
              scr_q <= SC_START;
              len_q <= nseek ? 4'd3 : 4'd10;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q <= cur;
            idx_q <= idx_q + 4'd1;
            if (idx_q == len_q - 4'd1) begin
              seq_q <= S_TAKE;
              dor_pre_q <= 1'b0;
            end
          end
        end
        default: seq_q <= S_TAKE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> seq_q == S_TAKE)
    else $error("event taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == S_EMIT) |-> idx_q < len_q)
    else $error("script index overrun");
endmodule

### hw/rtl/floppy_sector_transfer_sequencer.sv
// Top level of the floppy sector transfer sequencer.
// Depends on fsts_pkg, fsts_front, fsts_back.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one event beat: set block,
//  transfer request, status byte, controller interrupt, tick, motor on/off.
//  Output channel (out_valid_o / out_stall_i) carries result beats: command
//  bytes, DOR writes, DMA arm and transfer done; last marks the final beat
//  an event produces.
//  A two-entry queue splits the front (accept) from the back (sequencer), so
//  input beats are taken while results wait to drain.
//  An event is taken by the back only while it is in its take state; each
//  result is registered in the emit state, one result per cycle while
//  out_stall_i is low. Set block runs the 16-bit block number through a
//  bit-serial divider; a status byte ending a phase passes a resolve state.
//  Throughput: one event per cycle when it yields no result and needs no
//  divider or resolve state. An event yields at most 11 result beats.
//  Reset: motor off, head position unknown, phase idle, default opcodes
//  and geometry. A stalled receiver holds the output beat and backs up
//  the queue, which then raises in_stall_o. The user makes config writes
//  (cfg_we_i, cfg_idx_i, cfg_data_i) only while idle; it is not enforced.
module floppy_sector_transfer_sequencer
  import fsts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] block_number_i,
  input  logic        write_flag_i,
  input  logic [7:0]  status_byte_i,
  input  logic [15:0] elapsed_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        dma_write_o,
  output logic [1:0]  done_status_o,
  output logic        last_o
);
  logic [7:0]  seek_q, sense_q, read_q, write_q, recal_q;
  logic [23:0] delay_q;
  logic [5:0]  spt_q;
  logic [1:0]  heads_q;

  // config register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seek_q <= 8'd15;
      sense_q <= 8'd8;
      read_q <= 8'd230;
      write_q <= 8'd197;
      recal_q <= 8'd7;
      delay_q <= 24'd3000000;
      spt_q <= 6'd18;
      heads_q <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        R_SEEK:  seek_q <= cfg_data_i[7:0];
        R_SENSE: sense_q <= cfg_data_i[7:0];
        R_READ:  read_q <= cfg_data_i[7:0];
        R_WRITE: write_q <= cfg_data_i[7:0];
        R_RECAL: recal_q <= cfg_data_i[7:0];
        R_DELAY: delay_q <= cfg_data_i;
        R_SPT:   spt_q <= cfg_data_i[5:0];
        R_HEADS: heads_q <= cfg_data_i[1:0];
        default: heads_q <= heads_q;
      endcase
    end
  end

  evt_t in_evt, q_evt;
  logic q_valid, q_pop;
  res_t res;

  assign in_evt = '{kind: kind_i, block_number: block_number_i,
                    write_flag: write_flag_i, status_byte: status_byte_i,
                    elapsed_us: elapsed_us_i};

  fsts_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_evt_i(in_evt),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_evt_o(q_evt)
  );

  fsts_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_evt_i(q_evt),
    .seek_op_i(seek_q), .sense_op_i(sense_q), .read_op_i(read_q),
    .write_op_i(write_q), .recal_op_i(recal_q), .delay_i(delay_q),
    .spt_i(spt_q), .heads_i(heads_q), .out_valid_o, .out_stall_i,
    .out_res_o(res)
  );

  assign out_kind_o = res.kind;
  assign out_byte_o = res.byte_v;
  assign dma_write_o = res.dma_write;
  assign done_status_o = res.done_status;
  assign last_o = res.last;
endmodule

### verif/fsts_checker.sv
// Result checker for the floppy sector transfer sequencer: watches input and
// config beats, predicts result beats and compares. Depends on fsts_pkg.
`timescale 1ns / 1ps
module fsts_checker
  import fsts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [15:0] block_number_i,
  input  logic        write_flag_i,
  input  logic [7:0]  status_byte_i,
  input  logic [15:0] elapsed_us_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  out_kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic        dma_write_i,
  input  logic [1:0]  done_status_i,
  input  logic        last_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef enum logic [1:0] {MotOff, MotDly, MotOn} motor_e;
  typedef enum logic [2:0] {
    PhIdle, PhSeekIrq, PhSeekSense, PhXferIrq, PhXferStat, PhRecalIrq, PhRecalSense
  } phase_e;

  logic [7:0]  seek_op, sense_op, read_op, write_op, recal_op;
  logic [23:0] off_delay;
  logic [5:0]  spt;
  logic [1:0]  heads;
  motor_e      motor;
  logic [24:0] countdown;
  logic [7:0]  trk, head_pos, st0, st1;
  logic        hd, is_wr;
  logic [6:0]  sec;
  phase_e      phase;
  logic [1:0]  tries;
  logic [2:0]  awaited;

  res_t beats_due[$];
  int   fails;

  assign fail_cnt_o = fails;
  assign pending_o  = beats_due.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fails++;
  endtask

  function automatic void push_beat(logic [1:0] k, logic [7:0] b, logic dw, logic [1:0] ds);
    res_t r;
    r = '{kind: k, byte_v: b, dma_write: dw, done_status: ds, last: 1'b0};
    beats_due.push_back(r);
  endfunction

  function automatic void spin_up();
    if (motor == MotOff) push_beat(OK_DOR, DorMotorOn, 1'b0, 2'd0);
    motor = MotOn;
  endfunction

  function automatic void spin_down();
    if (motor == MotOn) begin
      motor = MotDly;
      countdown = {1'b0, off_delay};
    end
  endfunction

  function automatic void end_xfer(logic [1:0] st);
    phase = PhIdle;
    awaited = 3'd0;
    push_beat(OK_DONE, 8'd0, 1'b0, st);
    spin_down();
  endfunction

  function automatic void begin_try();
    if (trk != head_pos) begin
      head_pos = trk;
      push_beat(OK_CMD, seek_op, 1'b0, 2'd0);
      push_beat(OK_CMD, {5'd0, hd, 2'd0}, 1'b0, 2'd0);
      push_beat(OK_CMD, trk, 1'b0, 2'd0);
      phase = PhSeekIrq;
      return;
    end
    push_beat(OK_DMA, 8'd0, is_wr, 2'd0);
    push_beat(OK_CMD, is_wr ? write_op : read_op, 1'b0, 2'd0);
    push_beat(OK_CMD, {5'd0, hd, 2'd0}, 1'b0, 2'd0);
    push_beat(OK_CMD, trk, 1'b0, 2'd0);
    push_beat(OK_CMD, {7'd0, hd}, 1'b0, 2'd0);
    push_beat(OK_CMD, {1'b0, sec}, 1'b0, 2'd0);
    push_beat(OK_CMD, 8'h02, 1'b0, 2'd0);
    push_beat(OK_CMD, 8'h12, 1'b0, 2'd0);
    push_beat(OK_CMD, 8'h1b, 1'b0, 2'd0);
    push_beat(OK_CMD, 8'hff, 1'b0, 2'd0);
    phase = PhXferIrq;
  endfunction

  function automatic void retry_or_give_up();
    if (tries > 2'd0) tries--;
    if (tries == 2'd0) end_xfer(2'd1);
    else begin_try();
  endfunction

  function automatic void predict_event(logic [2:0] k, logic [15:0] blk, logic wr,
                                        logic [7:0] sb, logic [15:0] el);
    int unsigned s, h, n0;
    n0 = beats_due.size();
    case (k)
      K_SET: if (phase == PhIdle) begin
        s = (spt == 6'd0) ? 1 : spt;
        h = (heads == 2'd0) ? 1 : ((heads > 2'd2) ? 2 : heads);
        trk = 8'((blk / (h * s)) & 8'hff);
        hd  = 1'((blk / s) % h);
        sec = 7'(blk % s + 1);
      end
      K_REQ: if (phase != PhIdle) push_beat(OK_DONE, 8'd0, 1'b0, 2'd2);
      else begin
        spin_up();
        is_wr = wr;
        tries = MaxTries;
        begin_try();
      end
      K_STAT: begin
        if (phase == PhSeekSense || phase == PhRecalSense) begin
          if (awaited > 3'd0) awaited--;
          if (awaited == 3'd0) begin
            if (phase == PhSeekSense) begin_try();
            else retry_or_give_up();
          end
        end else if (phase == PhXferStat) begin
          if (awaited == 3'd7) st0 = sb;
          else if (awaited == 3'd6) st1 = sb;
          if (awaited > 3'd0) awaited--;
          if (awaited == 3'd0) begin
            if ((st0 & 8'hc0) == 8'h40 && st1[2]) begin
              head_pos = 8'd0;
              push_beat(OK_CMD, recal_op, 1'b0, 2'd0);
              push_beat(OK_CMD, 8'h00, 1'b0, 2'd0);
              phase = PhRecalIrq;
            end else if ((st0 & 8'hc0) == 8'h00) end_xfer(2'd0);
            else retry_or_give_up();
          end
        end
      end
      K_IRQ: begin
        if (phase == PhSeekIrq || phase == PhRecalIrq) begin
          push_beat(OK_CMD, sense_op, 1'b0, 2'd0);
          phase = (phase == PhSeekIrq) ? PhSeekSense : PhRecalSense;
          awaited = 3'd2;
        end else if (phase == PhXferIrq) begin
          phase = PhXferStat;
          awaited = 3'd7;
        end
      end
      K_TICK: if (motor == MotDly) begin
        if (25'(el) >= countdown) begin
          countdown = 25'd0;
          motor = MotOff;
          push_beat(OK_DOR, DorMotorOff, 1'b0, 2'd0);
        end else countdown -= 25'(el);
      end
      K_MON:  spin_up();
      K_MOFF: spin_down();
      default: ;
    endcase
    if (beats_due.size() > n0) beats_due[beats_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      seek_op = 8'd15; sense_op = 8'd8; read_op = 8'd230; write_op = 8'd197;
      recal_op = 8'd7; off_delay = 24'd3000000; spt = 6'd18; heads = 2'd2;
      motor = MotOff; countdown = '0; trk = '0; hd = 1'b0; sec = 7'd1;
      head_pos = 8'hff; phase = PhIdle; is_wr = 1'b0; tries = 2'd0; awaited = 3'd0;
      st0 = 8'd0; st1 = 8'd0;
      fails = 0;
      beats_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          R_SEEK:  seek_op  = cfg_data_i[7:0];
          R_SENSE: sense_op = cfg_data_i[7:0];
          R_READ:  read_op  = cfg_data_i[7:0];
          R_WRITE: write_op = cfg_data_i[7:0];
          R_RECAL: recal_op = cfg_data_i[7:0];
          R_DELAY: off_delay = cfg_data_i;
          R_SPT:   spt   = cfg_data_i[5:0];
          R_HEADS: heads = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        predict_event(kind_i, block_number_i, write_flag_i, status_byte_i, elapsed_us_i);
      if (out_valid_i && !out_stall_i) begin
        if (beats_due.size() == 0) report("result beat with none expected");
        else begin
          e = beats_due.pop_front();
          if (out_kind_i != e.kind)
            report($sformatf("out_kind %0d, want %0d", out_kind_i, e.kind));
          if (out_byte_i != e.byte_v)
            report($sformatf("out_byte %0h, want %0h", out_byte_i, e.byte_v));
          if (dma_write_i != e.dma_write)
            report($sformatf("dma_write %0b, want %0b", dma_write_i, e.dma_write));
          if (done_status_i != e.done_status)
            report($sformatf("done_status %0d, want %0d", done_status_i, e.done_status));
          if (last_i != e.last)
            report($sformatf("last %0b, want %0b", last_i, e.last));
        end
      end
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top for the floppy sector transfer sequencer: clock, reset,
// config writes, event beats and verdict. Depends on fsts_pkg, fsts_checker.
`timescale 1ns / 1ps
module tb_top;
  import fsts_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [23:0] cfg_data;
  logic        in_valid, in_stall;
  logic [2:0]  kind;
  logic [15:0] blk;
  logic        wr;
  logic [7:0]  sb;
  logic [15:0] el;
  logic        out_valid, out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        dma_wr, last;
  logic [1:0]  done_st;
  int          fails, pending, cycles;
  bit          calm;  // no idling on either side while set

  floppy_sector_transfer_sequencer i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .block_number_i(blk), .write_flag_i(wr),
    .status_byte_i(sb), .elapsed_us_i(el),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_kind_o(out_kind), .out_byte_o(out_byte), .dma_write_o(dma_wr),
    .done_status_o(done_st), .last_o(last)
  );

  fsts_checker i_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .kind_i(kind), .block_number_i(blk), .write_flag_i(wr),
    .status_byte_i(sb), .elapsed_us_i(el),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_kind_i(out_kind), .out_byte_i(out_byte), .dma_write_i(dma_wr),
    .done_status_i(done_st), .last_i(last),
    .fail_cnt_o(fails), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver stalls at random with probability 27 in 100, never while calm
  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 27);

  // one event beat; sender gaps drawn before the beat
  task automatic send(input logic [2:0] k, input logic [15:0] b, input logic w,
                      input logic [7:0] s, input logic [15:0] e);
    while (!calm && $urandom_range(99) < 27) @(negedge clk);
    in_valid = 1'b1; kind = k; blk = b; wr = w; sb = s; el = e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_k(input logic [2:0] k);
    send(k, 16'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // wait until every expected beat has drained, plus latency margin
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg(input logic [2:0] idx, input logic [23:0] d);
    cfg_we = 1'b1; cfg_idx = idx; cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // status bytes for one transfer: good, sector-not-found, other failure or random
  task automatic xfer_stats(input int mode);
    logic [7:0] s0, s1;
    case (mode)
      0: begin s0 = 8'($urandom) & 8'h3f; s1 = 8'($urandom); end
      1: begin s0 = 8'h40 | (8'($urandom) & 8'h3f); s1 = 8'($urandom) | 8'h04; end
      2: begin s0 = 8'h80 | 8'($urandom); s1 = 8'($urandom); end
      default: begin s0 = 8'($urandom); s1 = 8'($urandom); end
    endcase
    send(K_STAT, 16'($urandom), 1'($urandom), s0, 16'($urandom));
    send(K_STAT, 16'($urandom), 1'($urandom), s1, 16'($urandom));
    repeat (5) send_k(K_STAT);
  endtask

  // a whole transfer run: seek if needed, attempts, recal paths
  task automatic run_xfer(input logic [15:0] b, input logic w, input int mode);
    send(K_SET, b, 1'($urandom), 8'($urandom), 16'($urandom));
    send(K_REQ, 16'($urandom), w, 8'($urandom), 16'($urandom));
    repeat (3) begin
      // seek / recal sense phases, harmless if not awaited
      send_k(K_IRQ); send_k(K_STAT); send_k(K_STAT);
      send_k(K_IRQ);
      if ($urandom_range(9) == 0) send_k(K_REQ);  // busy refusal
      xfer_stats(mode < 0 ? $urandom_range(3) : mode);
    end
  endtask

  int n;

  initial begin
    calm = 0;
    rst_n = 0; cfg_we = 0; cfg_idx = R_SEEK; cfg_data = 0;
    in_valid = 0; kind = K_SET; blk = 0; wr = 0; sb = 0; el = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: defaults, extremes of block number, each outcome
    run_xfer(16'd0, 1'b0, 0);
    run_xfer(16'hffff, 1'b1, 1);
    run_xfer(16'd37, 1'b0, 2);
    send(3'd7, 16'hffff, 1'b1, 8'hff, 16'hffff);        // unknown kind
    send_k(K_MON); send_k(K_MOFF);
    send(K_TICK, 16'd0, 1'b0, 8'd0, 16'd0);
    send(K_TICK, 16'd0, 1'b0, 8'd0, 16'hffff);
    drain();

    // zero geometry and extreme opcodes, zero off delay
    cfg(R_SEEK, 24'hff); cfg(R_SENSE, 24'h0); cfg(R_READ, 24'hff);
    cfg(R_WRITE, 24'h0); cfg(R_RECAL, 24'hff); cfg(R_DELAY, 24'd0);
    cfg(R_SPT, 24'd0); cfg(R_HEADS, 24'd0);
    run_xfer(16'd300, 1'b1, 1);
    send(K_TICK, 16'd0, 1'b0, 8'd0, 16'd0);
    send_k(K_MON); send_k(K_MON); send_k(K_MOFF); send_k(K_MON);
    drain();

    // max geometry, head count 3, max delay
    cfg(R_SPT, 24'd63); cfg(R_HEADS, 24'd3); cfg(R_DELAY, 24'hffffff);
    cfg(R_SEEK, 24'h5a); cfg(R_READ, 24'h01);
    n = 0;
    calm = 1;  // stretch with no idling
    while (n < 35) begin
      if ($urandom_range(4) == 0) begin
        send_k(3'($urandom_range(7))); n++;
      end else begin
        run_xfer(16'($urandom), 1'($urandom), -1); n += 35;
      end
    end
    calm = 0;
    drain();

    // small geometry, short delay so ticks switch the motor off
    cfg(R_SPT, 24'd1); cfg(R_HEADS, 24'd1); cfg(R_DELAY, 24'd500);
    cfg(R_WRITE, 24'h3c); cfg(R_SENSE, 24'hc3); cfg(R_RECAL, 24'h11);
    n = 0;
    while (n < 35) begin
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(1)) send(K_TICK, 16'd0, 1'b0, 8'd0, 16'($urandom_range(400)));
        else send_k(3'($urandom_range(7)));
        n++;
      end else begin
        run_xfer(16'($urandom_range(300)), 1'($urandom), -1); n += 35;
      end
    end
    drain();

    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fsts_pkg.sv
hw/rtl/fsts_front.sv
hw/rtl/fsts_div.sv
hw/rtl/fsts_back.sv
hw/rtl/floppy_sector_transfer_sequencer.sv
verif/fsts_checker.sv
verif/tb_top.sv
